// File: rtl/bfsp_pkg.sv
// bfsp_pkg: shared types and constants of the shortest-path block
// sequencer state codes, configuration register codes and fixed field widths
// no dependencies
`default_nettype none

package bfsp_pkg;

  localparam int VIDX_W     = 5;
  localparam int DIST_OUT_W = 32;
  localparam int VCNT_W     = 6;
  localparam int SRC_W      = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int OUT_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE       = 4'd1;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_INIT     = 9'b000000010,
    ST_ROW      = 9'b000000100,
    ST_ROW_LAT  = 9'b000001000,
    ST_EDGE_RD  = 9'b000010000,
    ST_EDGE_UPD = 9'b000100000,
    ST_OUT_RD   = 9'b001000000,
    ST_OUT_CAP  = 9'b010000000,
    ST_OUT_WAIT = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

// File: rtl/bfsp_ram.sv
// bfsp_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none

module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/bellman_ford_shortest_paths.sv
// bellman_ford_shortest_paths: single-source shortest paths over a dense matrix
// depends on bfsp_pkg and bfsp_ram
//
// Matrix entries stream in row-major order, one transfer per cycle while the
// block is idle; the transfer with tlast starts a run from the configured
// source. The run relaxes one edge at a time through a single adder and
// comparator and a simple dual-port distance table, skipping unreachable
// rows; one sweep covers all n rows. Up to n-1 relaxing sweeps run, ending
// early after a sweep without change, and one checking sweep follows when
// all of them ran and the last changed a distance. One result per vertex is
// then sent. Input is not accepted from the tlast transfer until the last
// result has been taken.
`default_nettype none

module bellman_ford_shortest_paths #(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // config write channel
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [bfsp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [bfsp_pkg::CFG_DATA_W-1:0]        cfg_data,
  // matrix entries
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // edge_weight, edge_present, zero fill
  input  wire logic [((WEIGHT_BITS+8)/8)*8-1:0]       s_tdata,
  input  wire logic                                   s_tlast,
  // results
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // vertex_index, distance, reachable, negative_cycle, zero fill
  output logic [bfsp_pkg::OUT_DATA_W-1:0]             m_tdata,
  output logic                                        m_tlast
);

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = WEIGHT_BITS + 1;
  localparam int DW    = WEIGHT_BITS + 2 * VW + 2;

  bfsp_pkg::state_t state;

  logic [bfsp_pkg::VCNT_W-1:0] vertex_count;
  logic [bfsp_pkg::SRC_W-1:0]  source_vertex;
  logic [AW-1:0]               load_pos;
  logic [CW-1:0]               n_reg;
  logic [CW-1:0]               passes;
  logic [VW-1:0]               row;
  logic [VW-1:0]               col;
  logic [VW-1:0]               vtx;
  logic [AW-1:0]               base;
  logic [MAX_VERTICES-1:0]     fin;
  logic signed [DW-1:0]        di;
  logic                        hit;
  logic                        check;
  logic                        cyc;

  logic [VW-1:0]               out_idx;
  logic [bfsp_pkg::DIST_OUT_W-1:0] out_dist;
  logic                        out_reach;
  logic                        out_neg;
  logic                        out_last;

  logic                        mat_we;
  logic [AW-1:0]               mat_raddr;
  logic [MW-1:0]               mat_rdata;
  logic                        dist_we;
  logic [VW-1:0]               dist_waddr;
  logic signed [DW-1:0]        dist_wdata;
  logic [VW-1:0]               dist_raddr;
  logic [DW-1:0]               dist_rdata;

  logic [CW-1:0]               n_start;
  logic [CW-1:0]               n_m1;
  logic                        src_ok;
  logic signed [WEIGHT_BITS-1:0] w;
  logic signed [DW-1:0]        dj;
  logic signed [DW-1:0]        cand;
  logic                        better;
  logic                        relax_hit;
  logic                        row_last;
  logic                        col_last;
  logic [CW-1:0]               passes_inc;
  logic [bfsp_pkg::DIST_OUT_W-1:0] dist_sat;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == bfsp_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= bfsp_pkg::VCNT_W'(32);
      source_vertex <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        bfsp_pkg::CFG_VERTEX_COUNT: vertex_count  <= cfg_data[bfsp_pkg::VCNT_W-1:0];
        bfsp_pkg::CFG_SOURCE:       source_vertex <= cfg_data[bfsp_pkg::SRC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vertex_count == '0) begin
      n_start = CW'(1);
    end else if ({1'b0, vertex_count} > (bfsp_pkg::VCNT_W + 1)'(MAX_VERTICES)) begin
      n_start = CW'(MAX_VERTICES);
    end else begin
      n_start = CW'(vertex_count);
    end
  end

  assign n_m1       = n_reg - CW'(1);
  assign src_ok     = (CW + bfsp_pkg::SRC_W)'(source_vertex) < (CW + bfsp_pkg::SRC_W)'(n_reg);
  assign w          = mat_rdata[WEIGHT_BITS-1:0];
  assign dj         = dist_rdata;
  assign cand       = di + DW'(w);
  assign better     = !fin[col] || (dj > cand);
  assign relax_hit  = mat_rdata[WEIGHT_BITS] && better;
  assign row_last   = (CW'(row) == n_m1);
  assign col_last   = (CW'(col) == n_m1);
  assign passes_inc = passes + CW'(1);

  generate
    if (DW > bfsp_pkg::DIST_OUT_W) begin : g_sat
      localparam logic signed [DW-1:0] SAT_MAX = DW'(32'sh7fffffff);
      localparam logic signed [DW-1:0] SAT_MIN = DW'(32'sh80000000);
      always_comb begin
        if ($signed(dist_rdata) > SAT_MAX) begin
          dist_sat = 32'h7fffffff;
        end else if ($signed(dist_rdata) < SAT_MIN) begin
          dist_sat = 32'h80000000;
        end else begin
          dist_sat = dist_rdata[bfsp_pkg::DIST_OUT_W-1:0];
        end
      end
    end else begin : g_ext
      assign dist_sat = bfsp_pkg::DIST_OUT_W'($signed(dist_rdata));
    end
  endgenerate

  always_comb begin
    mat_we     = (state == bfsp_pkg::ST_IDLE) && s_tvalid;
    mat_raddr  = base + AW'(col);
    dist_we    = 1'b0;
    dist_waddr = col;
    dist_wdata = cand;
    dist_raddr = col;
    case (state)
      bfsp_pkg::ST_INIT: begin
        dist_we    = src_ok;
        dist_waddr = VW'(source_vertex);
        dist_wdata = '0;
      end
      bfsp_pkg::ST_ROW:      dist_raddr = row;
      bfsp_pkg::ST_EDGE_UPD: dist_we    = relax_hit && !check;
      bfsp_pkg::ST_OUT_RD:   dist_raddr = vtx;
      default: ;
    endcase
  end

  bfsp_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_matrix (
    .clk   (clk),
    .we    (mat_we),
    .waddr (load_pos),
    .wdata (s_tdata[MW-1:0]),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  bfsp_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_dist (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bfsp_pkg::ST_IDLE;
      load_pos <= '0;
      n_reg    <= CW'(1);
      passes   <= '0;
      row      <= '0;
      col      <= '0;
      vtx      <= '0;
      base     <= '0;
      fin      <= '0;
      hit      <= 1'b0;
      check    <= 1'b0;
      cyc      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        bfsp_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tlast) begin
              load_pos <= '0;
              n_reg    <= n_start;
              state    <= bfsp_pkg::ST_INIT;
            end else if (load_pos == AW'(DEPTH - 1)) begin
              load_pos <= '0;
            end else begin
              load_pos <= load_pos + AW'(1);
            end
          end
        end
        bfsp_pkg::ST_INIT: begin
          fin    <= src_ok ? (MAX_VERTICES'(1) << source_vertex) : '0;
          passes <= '0;
          cyc    <= 1'b0;
          hit    <= 1'b0;
          row    <= '0;
          base   <= '0;
          check  <= (n_reg == CW'(1));
          state  <= bfsp_pkg::ST_ROW;
        end
        bfsp_pkg::ST_ROW: begin
          if (fin[row]) begin
            state <= bfsp_pkg::ST_ROW_LAT;
          end else if (!row_last) begin
            row  <= row + VW'(1);
            base <= base + AW'(n_reg);
          end else begin
            row  <= '0;
            base <= '0;
            hit  <= 1'b0;
            if (check) begin
              cyc   <= hit;
              vtx   <= '0;
              state <= bfsp_pkg::ST_OUT_RD;
            end else begin
              passes <= passes_inc;
              if (!hit) begin
                vtx   <= '0;
                state <= bfsp_pkg::ST_OUT_RD;
              end else if (passes_inc == n_m1) begin
                check <= 1'b1;
              end
            end
          end
        end
        bfsp_pkg::ST_ROW_LAT: begin
          di    <= dist_rdata;
          col   <= '0;
          state <= bfsp_pkg::ST_EDGE_RD;
        end
        bfsp_pkg::ST_EDGE_RD: begin
          state <= bfsp_pkg::ST_EDGE_UPD;
        end
        bfsp_pkg::ST_EDGE_UPD: begin
          if (relax_hit) begin
            if (!(col_last && row_last)) begin
              hit <= 1'b1;
            end
            if (!check) begin
              fin[col] <= 1'b1;
              if (col == row) begin
                di <= cand;
              end
            end
          end
          if (!col_last) begin
            col   <= col + VW'(1);
            state <= bfsp_pkg::ST_EDGE_RD;
          end else if (!row_last) begin
            row   <= row + VW'(1);
            base  <= base + AW'(n_reg);
            state <= bfsp_pkg::ST_ROW;
          end else begin
            row  <= '0;
            base <= '0;
            hit  <= 1'b0;
            if (check) begin
              cyc   <= hit || relax_hit;
              vtx   <= '0;
              state <= bfsp_pkg::ST_OUT_RD;
            end else begin
              passes <= passes_inc;
              if (!(hit || relax_hit)) begin
                vtx   <= '0;
                state <= bfsp_pkg::ST_OUT_RD;
              end else begin
                if (passes_inc == n_m1) begin
                  check <= 1'b1;
                end
                state <= bfsp_pkg::ST_ROW;
              end
            end
          end
        end
        bfsp_pkg::ST_OUT_RD: begin
          state <= bfsp_pkg::ST_OUT_CAP;
        end
        bfsp_pkg::ST_OUT_CAP: begin
          out_idx   <= vtx;
          out_dist  <= fin[vtx] ? dist_sat : '0;
          out_reach <= fin[vtx];
          out_neg   <= cyc;
          out_last  <= (CW'(vtx) == n_m1);
          m_tvalid  <= 1'b1;
          state     <= bfsp_pkg::ST_OUT_WAIT;
        end
        bfsp_pkg::ST_OUT_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (out_last) begin
              state <= bfsp_pkg::ST_IDLE;
            end else begin
              vtx   <= vtx + VW'(1);
              state <= bfsp_pkg::ST_OUT_RD;
            end
          end
        end
        default: state <= bfsp_pkg::ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {1'b0, out_neg, out_reach, out_dist, bfsp_pkg::VIDX_W'(out_idx)};
  assign m_tlast = out_last;

endmodule

`default_nettype wire

// File: sim/bellman_ford_shortest_paths_tb.sv
// bellman_ford_shortest_paths_tb: self-checking bench for the shortest-path block
// streams adjacency matrices, predicts per-vertex distances and compares every result
// depends on bfsp_pkg and the bellman_ford_shortest_paths rtl
`default_nettype none

module bellman_ford_shortest_paths_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VIDX_W      = bfsp_pkg::VIDX_W;
  localparam int DIST_OUT_W  = bfsp_pkg::DIST_OUT_W;
  localparam int VCNT_W      = bfsp_pkg::VCNT_W;
  localparam int SRC_W       = bfsp_pkg::SRC_W;
  localparam int CFG_IDX_W   = bfsp_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = bfsp_pkg::CFG_DATA_W;
  localparam int OUT_DATA_W  = bfsp_pkg::OUT_DATA_W;

  localparam int MAX_V       = 32;
  localparam int WBITS       = 16;
  localparam int MAT_CELLS   = MAX_V * MAX_V;
  localparam int IN_DATA_W   = ((WBITS + 8) / 8) * 8;
  localparam int SMALL_ITEMS = 360;
  localparam int MIN_SEGS    = 4;
  localparam int HOLD_LEN    = 3000;
  localparam int QUIET_LIMIT = 300000;
  localparam int SETTLE      = 8;
  localparam int TAIL        = 40;
  localparam int MAX_REPORTS = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'hF;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idling_t;

  typedef struct packed {
    logic signed [WBITS-1:0] weight;
    logic                    present;
    logic                    last;
  } entry_t;

  typedef struct packed {
    logic [VIDX_W-1:0]            vidx;
    logic signed [DIST_OUT_W-1:0] distance;
    logic                         reach;
    logic                         negcyc;
    logic                         last;
  } vresult_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tlast;

  bellman_ford_shortest_paths #(
    .MAX_VERTICES(MAX_V),
    .WEIGHT_BITS (WBITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // stimulus and expectations
  entry_t   entry_q[$];
  vresult_t dist_expect_q[$];

  // predictor state
  logic              adj_on [MAT_CELLS];
  logic signed [WBITS-1:0] adj_wt [MAT_CELLS];
  bit                dist_ok [MAX_V];
  longint            dist_val [MAX_V];
  int                wr_ptr = 0;
  logic [VCNT_W-1:0] cfg_vertices = 6'd32;
  logic [SRC_W-1:0]  cfg_source = '0;

  // generator bookkeeping
  int gen_n = MAX_V;
  int gen_pos = 0;
  int gen_hi = 0;

  int  gap_pct = 0;
  int  stall_pct = 0;
  bit  long_hold_req = 1'b0;
  int  hold_count = 0;
  bit  in_fire = 1'b0;
  int  quiet_cycles = 0;
  int  mismatches = 0;
  int  entries_taken = 0;
  int  runs_done = 0;
  int  neg_runs = 0;
  int  results_checked = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit relax_all(int n, bit update);
    int i, j, idx;
    longint cand;
    bit hit;
    hit = 1'b0;
    for (i = 0; i < n; i++) begin
      if (!dist_ok[i]) continue;
      for (j = 0; j < n; j++) begin
        idx = (i * n + j) % MAT_CELLS;
        if (!adj_on[idx]) continue;
        cand = dist_val[i] + longint'(adj_wt[idx]);
        if (!dist_ok[j] || dist_val[j] > cand) begin
          hit = 1'b1;
          if (!update) return 1'b1;
          dist_ok[j] = 1'b1;
          dist_val[j] = cand;
        end
      end
    end
    return hit;
  endfunction

  // store one matrix entry; on the last entry solve and queue per-vertex results
  function automatic void absorb_entry(entry_t e);
    int n, p, v, passes;
    bit neg;
    longint d;
    vresult_t r;
    adj_wt[wr_ptr] = e.weight;
    adj_on[wr_ptr] = e.present;
    wr_ptr = (wr_ptr + 1) % MAT_CELLS;
    if (!e.last) return;
    wr_ptr = 0;
    n = int'(cfg_vertices);
    if (n < 1) n = 1;
    if (n > MAX_V) n = MAX_V;
    for (v = 0; v < n; v++) begin
      dist_ok[v] = 1'b0;
      dist_val[v] = 0;
    end
    if (int'(cfg_source) < n) dist_ok[cfg_source] = 1'b1;
    passes = 0;
    for (p = 0; p + 1 < n; p++) begin
      passes++;
      if (!relax_all(n, 1'b1)) break;
    end
    neg = 1'b0;
    if (passes == n - 1) neg = relax_all(n, 1'b0);
    for (v = 0; v < n; v++) begin
      d = dist_ok[v] ? dist_val[v] : 0;
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      if (d < -64'sd2147483648) d = -64'sd2147483648;
      r.vidx     = VIDX_W'(v);
      r.distance = d[DIST_OUT_W-1:0];
      r.reach    = dist_ok[v];
      r.negcyc   = neg;
      r.last     = (v == n - 1);
      dist_expect_q.push_back(r);
    end
    runs_done++;
    if (neg) neg_runs++;
  endfunction

  // input acceptance, result checking and watchdog
  always @(posedge clk) begin : observe
    entry_t   acc;
    vresult_t got, exp_r;
    bit       busy;
    in_fire = s_tvalid && s_tready;
    if (!rst) begin
      busy = in_fire || (m_tvalid && m_tready) || (cfg_valid && cfg_ready);
      if (in_fire) begin
        acc.weight  = s_tdata[WBITS-1:0];
        acc.present = s_tdata[WBITS];
        acc.last    = s_tlast;
        entries_taken++;
        absorb_entry(acc);
      end
      if (m_tvalid && m_tready) begin
        got.vidx     = m_tdata[VIDX_W-1:0];
        got.distance = m_tdata[VIDX_W +: DIST_OUT_W];
        got.reach    = m_tdata[VIDX_W+DIST_OUT_W];
        got.negcyc   = m_tdata[VIDX_W+DIST_OUT_W+1];
        got.last     = m_tlast;
        if (dist_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: vertex %0d dist %0d reach %0b neg %0b last %0b",
                     got.vidx, got.distance, got.reach, got.negcyc, got.last);
        end else begin
          exp_r = dist_expect_q.pop_front();
          results_checked++;
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch: exp vertex %0d dist %0d reach %0b neg %0b last %0b",
                       exp_r.vidx, exp_r.distance, exp_r.reach, exp_r.negcyc, exp_r.last);
              $display("          got vertex %0d dist %0d reach %0b neg %0b last %0b",
                       got.vidx, got.distance, got.reach, got.negcyc, got.last);
            end
          end
        end
      end
      if (busy) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // matrix entry driver
  always @(negedge clk) begin : feed
    entry_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (entry_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nxt = entry_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-WBITS-1){1'b0}}, nxt.present, nxt.weight};
        s_tlast  <= nxt.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result sink with one long hold-off on request
  always @(negedge clk) begin : sink
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_hold_req && hold_count < HOLD_LEN) begin
      hold_count <= hold_count + 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == bfsp_pkg::CFG_VERTEX_COUNT) cfg_vertices = data[VCNT_W-1:0];
    else if (idx == bfsp_pkg::CFG_SOURCE) cfg_source = data[SRC_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [VCNT_W-1:0] vc, logic [SRC_W-1:0] src);
    write_reg(bfsp_pkg::CFG_VERTEX_COUNT, {2'($urandom_range(3)), vc});
    write_reg(bfsp_pkg::CFG_SOURCE, {3'($urandom_range(7)), src});
    gen_n = (vc == 0) ? 1 : (vc > MAX_V) ? MAX_V : int'(vc);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (entry_q.size() != 0 || s_tvalid || dist_expect_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_entry(logic signed [WBITS-1:0] w, logic present, logic last);
    entry_t e;
    e.weight = w;
    e.present = present;
    e.last = last;
    entry_q.push_back(e);
    gen_pos++;
    if (last) begin
      if (gen_pos > gen_hi) gen_hi = gen_pos;
      gen_pos = 0;
    end
  endtask

  function automatic logic signed [WBITS-1:0] rand_weight(int style);
    case (style)
      0: return WBITS'($urandom_range(0, 60));
      1: begin
        if ($urandom_range(99) < 70) return WBITS'($urandom_range(0, 40));
        return WBITS'(0 - $urandom_range(1, 25));
      end
      default: return WBITS'($urandom);
    endcase
  endfunction

  // mostly full matrices; some short or overlong frames once the prefix is loaded
  function automatic int frame_len(int n);
    int len;
    len = n * n;
    if ($urandom_range(99) < 20) begin
      len = $urandom_range(1, n * n + 6);
      if (len > MAT_CELLS) len = MAT_CELLS;
      if (len < n * n && gen_hi < n * n) len = n * n;
    end
    return len;
  endfunction

  task automatic make_frame(int len, int style, int density);
    int k;
    for (k = 0; k < len; k++)
      push_entry(rand_weight(style), $urandom_range(99) < density, k == len - 1);
  endtask

  function automatic logic [VCNT_W-1:0] pick_vertices();
    int r;
    r = $urandom_range(99);
    if (r < 6) return 6'd0;
    if (r < 12) return 6'd1;
    if (r < 75) return VCNT_W'($urandom_range(2, 5));
    if (r < 93) return VCNT_W'($urandom_range(6, 9));
    return VCNT_W'($urandom_range(10, 14));
  endfunction

  function automatic logic [SRC_W-1:0] pick_source(int n);
    int r;
    r = $urandom_range(99);
    if (r < 75) return SRC_W'($urandom_range(0, n - 1));
    if (r < 85) return 5'd31;
    return SRC_W'($urandom_range(0, 31));
  endfunction

  task automatic set_idling(idling_t mode);
    case (mode)
      IDLE_NONE: begin gap_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin gap_pct = 65; stall_pct = 0;  end
      IDLE_RECV: begin gap_pct = 0;  stall_pct = 65; end
      default:   begin gap_pct = 24; stall_pct = 24; end
    endcase
  endtask

  initial begin : stimulus
    int seg, f, nframes, len, small_items;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    m_tready  = 1'b0;
    small_items = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_idle();

    // single vertex: a negative self loop is a cycle, a positive one is not
    write_reg(CFG_UNUSED, 8'hFF);
    write_reg(bfsp_pkg::CFG_VERTEX_COUNT, 8'h40);
    write_reg(bfsp_pkg::CFG_SOURCE, 8'h00);
    gen_n = 1;
    push_entry(-16'sd32768, 1'b1, 1'b1);
    push_entry(16'sd32767, 1'b1, 1'b1);
    wait_idle();

    // source beyond the vertex count: nothing reachable
    write_reg(bfsp_pkg::CFG_VERTEX_COUNT, 8'hC2);
    write_reg(bfsp_pkg::CFG_SOURCE, 8'hE3);
    gen_n = 2;
    push_entry(16'sd32767, 1'b1, 1'b0);
    push_entry(-16'sd32768, 1'b1, 1'b0);
    push_entry(16'sd0, 1'b0, 1'b0);
    push_entry(-16'sd1, 1'b1, 1'b1);
    wait_idle();

    // most negative weight into vertex 0, all other entries absent
    write_reg(bfsp_pkg::CFG_SOURCE, 8'h01);
    push_entry(16'sd0, 1'b0, 1'b0);
    push_entry(16'sd0, 1'b0, 1'b0);
    push_entry(-16'sd32768, 1'b1, 1'b0);
    push_entry(16'sd5, 1'b0, 1'b1);
    wait_idle();

    // reachable negative cycle between vertices 1 and 2
    set_config(6'd3, 5'd0);
    push_entry(16'sd0, 1'b0, 1'b0);
    push_entry(16'sd5, 1'b1, 1'b0);
    push_entry(16'sd0, 1'b0, 1'b0);
    push_entry(16'sd0, 1'b0, 1'b0);
    push_entry(16'sd0, 1'b0, 1'b0);
    push_entry(-16'sd3, 1'b1, 1'b0);
    push_entry(16'sd0, 1'b0, 1'b0);
    push_entry(-16'sd4, 1'b1, 1'b0);
    push_entry(16'sd0, 1'b0, 1'b1);
    wait_idle();

    seg = 0;
    while (small_items < SMALL_ITEMS || seg < MIN_SEGS) begin
      set_idling(idling_t'(seg % 4));
      set_config(pick_vertices(), 5'd0);
      write_reg(bfsp_pkg::CFG_SOURCE, {3'($urandom_range(7)), pick_source(gen_n)});
      if (seg == 2) long_hold_req = 1'b1;
      nframes = $urandom_range(2, 4);
      for (f = 0; f < nframes; f++) begin
        len = frame_len(gen_n);
        make_frame(len, $urandom_range(2), $urandom_range(15, 70));
        small_items += len;
      end
      wait_idle();
      seg++;
    end

    repeat (TAIL) @(posedge clk);
    $display("covered %0d matrix entries over %0d runs (%0d with a negative cycle)",
             entries_taken, runs_done, neg_runs);
    $display("checked %0d vertex results across %0d idling phases, %0d mismatches",
             results_checked, seg, mismatches);
    if (mismatches == 0 && dist_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
